// ===== rtl/gsld_pkg.sv =====
package gsld_pkg;

	// Fixed port widths
	localparam int UNIV_W  = 24;
	localparam int VALUE_W = 25;

	// Divisor rule constants
	localparam int MUL_W = 24;
	localparam logic [MUL_W-1:0] C_MUL = 24'd10557376;   // twice the scale factor
	localparam logic [MUL_W-1:0] C_OFS = 24'd2336849;    // offset added after the divide
	localparam logic [MUL_W-1:0] C_DIV = 24'd15231074;   // divisor above the table range

	localparam int CRIT_W = 28;
	localparam int CRIT_N = 10;
	localparam logic [CRIT_W-1:0] T_LIMIT = 28'd167474174;

	// Upper bound of t for each small divisor, smallest divisor first
	localparam logic [CRIT_W-1:0] CRIT_TAB [CRIT_N] = '{
		28'd29976418,  28'd45406673,  28'd60720539,  28'd75997183,  28'd91257138,
		28'd106508163, 28'd121753849, 28'd136996088, 28'd152235971, 28'd167474174
	};

endpackage

// ===== rtl/golomb_sorted_list_decoder_core.sv =====
// Channel | Signals                                                | Direction
// --------+--------------------------------------------------------+----------
// input   | in_valid, in_ready, data_byte, start_list              | in
// output  | out_valid, out_ready, value, last, empty_list, corrupt | out
// config  | cfg_wr_en, cfg_wr_data (universe size)                 | in
//
// A byte is accepted, then decoded one code bit per cycle while the output register is not
// stalled; outside a list it is dropped. A completed header adds a multiply step, a shared
// restoring divider pass, the offset add and table lookup, a second divider pass when t is
// above the table, and the bit-length search.
// Reset is asynchronous and clears all state at once; no clearing pass.
// The bit engine freezes while a result sits in the output register untaken.
module golomb_sorted_list_decoder_core #(
	parameter int HEADER_BITS   = 16,
	parameter int UNIVERSE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [gsld_pkg::UNIV_W-1:0]          cfg_wr_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           data_byte,
	input  logic                                 start_list,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [gsld_pkg::VALUE_W-1:0]         value,
	output logic                                 last,
	output logic                                 empty_list,
	output logic                                 corrupt
);

	localparam int HB  = HEADER_BITS;
	localparam int NW  = (UNIVERSE_BITS < gsld_pkg::UNIV_W) ? UNIVERSE_BITS : gsld_pkg::UNIV_W;
	localparam int SW  = ((NW > HB) ? NW : HB) + 1;
	localparam int RW  = SW;
	localparam int MW  = NW;
	localparam int PW  = gsld_pkg::MUL_W + SW;
	localparam int QW  = PW + 1;
	localparam int DVW = (HB > gsld_pkg::MUL_W) ? HB : gsld_pkg::MUL_W;
	localparam int KW  = $clog2(MW + 1);
	localparam int BPW = $clog2(((HB > MW) ? HB : MW) + 1);
	localparam int ITW = $clog2(QW + 1);
	localparam int VW  = gsld_pkg::VALUE_W;

	// List phase
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_CODE   = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	// Codeword phase
	localparam logic [1:0] CP_UNARY = 2'd0;
	localparam logic [1:0] CP_REM   = 2'd1;
	localparam logic [1:0] CP_EXTRA = 2'd2;

	// Sequencer
	localparam logic [2:0] SQ_WAIT = 3'd0;
	localparam logic [2:0] SQ_BITS = 3'd1;
	localparam logic [2:0] SQ_MUL  = 3'd2;
	localparam logic [2:0] SQ_DIV  = 3'd3;
	localparam logic [2:0] SQ_ADD  = 3'd4;
	localparam logic [2:0] SQ_TAB  = 3'd5;
	localparam logic [2:0] SQ_LEN  = 3'd6;

	logic [2:0]                 sq_q;
	logic [gsld_pkg::UNIV_W-1:0] univ_q;
	logic [7:0]                 byte_q;
	logic [3:0]                 bit_cnt_q;
	logic [1:0]                 phase_q;
	logic [HB-1:0]              hdr_q;
	logic [BPW-1:0]             bp_q;
	logic [HB-1:0]              vr_q;
	logic [RW-1:0]              rv_q;
	logic [SW-1:0]              sum_q;
	logic [MW-1:0]              m_q;
	logic [KW-1:0]              k_q;
	logic [MW-1:0]              trunc_q;
	logic [MW-1:0]              ra_q;
	logic [1:0]                 cp_q;
	logic [MW:0]                p_q;

	// Shared divider
	logic [QW-1:0]              q_q;
	logic [DVW-1:0]             rem_q;
	logic [DVW-1:0]             dvs_q;
	logic [ITW-1:0]             it_q;
	logic                       div2_q;
	logic [QW-1:0]              t_q;

	// Output register
	logic                       out_valid_q;
	logic [VW-1:0]              value_q;
	logic                       last_q;
	logic                       empty_q;
	logic                       corrupt_q;

	// Bit engine next state
	logic                       bit_b;
	logic [1:0]                 ph_n;
	logic [HB-1:0]              hdr_n;
	logic [BPW-1:0]             bp_n;
	logic [HB-1:0]              vr_n;
	logic [RW-1:0]              rv_n;
	logic [SW-1:0]              sum_n;
	logic [MW-1:0]              ra_n;
	logic [1:0]                 cp_n;
	logic                       emit;
	logic [VW-1:0]              e_val;
	logic                       e_last;
	logic                       e_empty;
	logic                       e_bad;
	logic                       hdr_fin;
	logic                       stop;
	logic                       tail;
	logic                       fin;
	logic [MW-1:0]              ra_t;
	logic [MW-1:0]              ra_f;
	logic [RW-1:0]              fin_v;
	logic [HB-1:0]              vr_dec;
	logic [VW+RW-1:0]           v_ext;
	logic                       step_go;
	logic                       emit_fire;

	// Divider and divisor set-up datapath
	logic [DVW:0]               div_sh;
	logic                       div_ge;
	logic [DVW-1:0]             rem_n;
	logic [QW-1:0]              q_n;
	logic [PW-1:0]              prod;
	logic [MW-1:0]              tab_m;

	assign in_ready   = (sq_q == SQ_WAIT);
	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign last       = last_q;
	assign empty_list = empty_q;
	assign corrupt    = corrupt_q;

	assign step_go   = !out_valid_q || out_ready;
	assign emit_fire = (sq_q == SQ_BITS) && !stop && step_go && emit;

	// Decode one code bit
	always_comb begin
		bit_b   = byte_q[7];
		ph_n    = phase_q;
		hdr_n   = hdr_q;
		bp_n    = bp_q;
		vr_n    = vr_q;
		rv_n    = rv_q;
		sum_n   = sum_q;
		ra_n    = ra_q;
		cp_n    = cp_q;
		emit    = 1'b0;
		e_val   = '0;
		e_last  = 1'b0;
		e_empty = 1'b0;
		e_bad   = 1'b0;
		hdr_fin = 1'b0;
		stop    = 1'b0;
		tail    = 1'b0;
		fin     = 1'b0;
		ra_t    = '0;
		ra_f    = '0;
		fin_v   = '0;
		vr_dec  = '0;
		v_ext   = '0;
		unique case (phase_q)
			PH_HEADER: begin
				hdr_n = HB'({hdr_q, bit_b});
				bp_n  = (bp_q != '0) ? bp_q - BPW'(1) : '0;
				if (bp_n == '0) begin
					if (hdr_n == '0) begin
						emit    = 1'b1;
						e_last  = 1'b1;
						e_empty = 1'b1;
						ph_n    = PH_DONE;
					end else begin
						hdr_fin = 1'b1;
						vr_n    = hdr_n;
						sum_n   = SW'(univ_q[NW-1:0]) + SW'(hdr_n);
						rv_n    = RW'(univ_q[NW-1:0]) + RW'(hdr_n) + RW'(1);
						ra_n    = '0;
						cp_n    = CP_UNARY;
						ph_n    = PH_CODE;
					end
				end
			end
			PH_CODE: begin
				unique case (cp_q)
					CP_UNARY: begin
						if (bit_b) begin
							rv_n = (rv_q >= RW'(m_q)) ? rv_q - RW'(m_q) : '0;
						end else begin
							ra_n = '0;
							bp_n = (k_q != '0) ? BPW'(k_q - KW'(1)) : '0;
							if (bp_n == '0) begin
								tail = 1'b1;
							end else begin
								cp_n = CP_REM;
							end
						end
					end
					CP_REM: begin
						ra_t = MW'({ra_q, bit_b});
						bp_n = (bp_q != '0) ? bp_q - BPW'(1) : '0;
						if (bp_n == '0) begin
							tail = 1'b1;
						end else begin
							ra_n = ra_t;
						end
					end
					CP_EXTRA: begin
						ra_f = MW'({ra_q, bit_b}) - trunc_q;
						fin  = 1'b1;
					end
					default: begin
						cp_n = CP_UNARY;
					end
				endcase
				// Long remainder needs one more bit
				if (tail) begin
					if (ra_t >= trunc_q) begin
						cp_n = CP_EXTRA;
						ra_n = ra_t;
					end else begin
						fin  = 1'b1;
						ra_f = ra_t;
					end
				end
				// Close the codeword and emit the running value
				if (fin) begin
					fin_v  = (rv_q >= RW'(ra_f)) ? rv_q - RW'(ra_f) : '0;
					vr_dec = (vr_q != '0) ? vr_q - HB'(1) : '0;
					rv_n   = fin_v;
					cp_n   = CP_UNARY;
					ra_n   = '0;
					vr_n   = vr_dec;
					emit   = 1'b1;
					if (fin_v == '0) begin
						e_last = 1'b1;
						e_bad  = 1'b1;
						ph_n   = PH_DONE;
					end else begin
						v_ext  = {{VW{1'b0}}, fin_v};
						e_val  = v_ext[VW-1:0];
						e_last = (vr_dec == '0);
						if (vr_dec == '0) begin
							ph_n = PH_DONE;
						end
					end
				end
			end
			default: begin
				stop = 1'b1;
			end
		endcase
	end

	// One restoring divide step
	always_comb begin
		div_sh = {rem_q, q_q[QW-1]};
		div_ge = (div_sh >= {1'b0, dvs_q});
		rem_n  = div_ge ? DVW'(div_sh - {1'b0, dvs_q}) : DVW'(div_sh);
		q_n    = {q_q[QW-2:0], div_ge};
	end

	// Scale the sum ahead of the divide
	assign prod = PW'(gsld_pkg::C_MUL) * PW'(sum_q);

	// Pick the smallest divisor whose bound covers t
	always_comb begin
		tab_m = MW'(gsld_pkg::CRIT_N);
		for (int i = gsld_pkg::CRIT_N - 1; i >= 0; i--) begin
			if (t_q <= QW'(gsld_pkg::CRIT_TAB[i])) begin
				tab_m = MW'(i + 1);
			end
		end
	end

	// Sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q        <= SQ_WAIT;
			univ_q      <= '0;
			byte_q      <= '0;
			bit_cnt_q   <= '0;
			phase_q     <= PH_IDLE;
			hdr_q       <= '0;
			bp_q        <= '0;
			vr_q        <= '0;
			rv_q        <= '0;
			sum_q       <= '0;
			m_q         <= MW'(1);
			k_q         <= '0;
			trunc_q     <= MW'(1);
			ra_q        <= '0;
			cp_q        <= CP_UNARY;
			p_q         <= '0;
			q_q         <= '0;
			rem_q       <= '0;
			dvs_q       <= '0;
			it_q        <= '0;
			div2_q      <= 1'b0;
			t_q         <= '0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			last_q      <= 1'b0;
			empty_q     <= 1'b0;
			corrupt_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				univ_q <= cfg_wr_data;
			end

			unique case (sq_q)
				SQ_WAIT: begin
					// Take the next request
					if (in_valid) begin
						byte_q    <= data_byte;
						bit_cnt_q <= 4'd8;
						sq_q      <= SQ_BITS;
						if (start_list) begin
							phase_q <= PH_HEADER;
							hdr_q   <= '0;
							bp_q    <= BPW'(HB);
							vr_q    <= '0;
							ra_q    <= '0;
							cp_q    <= CP_UNARY;
						end
					end
				end
				SQ_BITS: begin
					if (stop) begin
						sq_q <= SQ_WAIT;
					end else if (step_go) begin
						phase_q   <= ph_n;
						hdr_q     <= hdr_n;
						bp_q      <= bp_n;
						vr_q      <= vr_n;
						rv_q      <= rv_n;
						sum_q     <= sum_n;
						ra_q      <= ra_n;
						cp_q      <= cp_n;
						byte_q    <= {byte_q[6:0], 1'b0};
						bit_cnt_q <= bit_cnt_q - 4'd1;
						if (hdr_fin) begin
							sq_q <= SQ_MUL;
						end else if (bit_cnt_q == 4'd1) begin
							sq_q <= SQ_WAIT;
						end
					end
				end
				SQ_MUL: begin
					// Load the divider with the scaled sum over the count
					q_q    <= QW'(prod);
					rem_q  <= '0;
					dvs_q  <= DVW'(vr_q);
					it_q   <= ITW'(QW);
					div2_q <= 1'b0;
					sq_q   <= SQ_DIV;
				end
				SQ_DIV: begin
					q_q   <= q_n;
					rem_q <= rem_n;
					it_q  <= it_q - ITW'(1);
					if (it_q == ITW'(1)) begin
						if (div2_q) begin
							m_q  <= MW'(q_n);
							p_q  <= (MW+1)'(1);
							k_q  <= '0;
							sq_q <= SQ_LEN;
						end else begin
							sq_q <= SQ_ADD;
						end
					end
				end
				SQ_ADD: begin
					t_q  <= q_q + QW'(gsld_pkg::C_OFS);
					sq_q <= SQ_TAB;
				end
				SQ_TAB: begin
					if (t_q <= QW'(gsld_pkg::T_LIMIT)) begin
						m_q  <= tab_m;
						p_q  <= (MW+1)'(1);
						k_q  <= '0;
						sq_q <= SQ_LEN;
					end else begin
						// Reuse the divider for t over the large-divisor constant
						q_q    <= t_q;
						rem_q  <= '0;
						dvs_q  <= DVW'(gsld_pkg::C_DIV);
						it_q   <= ITW'(QW);
						div2_q <= 1'b1;
						sq_q   <= SQ_DIV;
					end
				end
				SQ_LEN: begin
					// Advance the power of two past the divisor
					if ({1'b0, m_q} >= p_q) begin
						p_q <= {p_q[MW-1:0], 1'b0};
						k_q <= k_q + KW'(1);
					end else begin
						trunc_q <= MW'(p_q - {1'b0, m_q});
						sq_q    <= (bit_cnt_q != 4'd0) ? SQ_BITS : SQ_WAIT;
					end
				end
				default: begin
					sq_q <= SQ_WAIT;
				end
			endcase

			// Hold a result until it is taken
			if (emit_fire) begin
				out_valid_q <= 1'b1;
				value_q     <= e_val;
				last_q      <= e_last;
				empty_q     <= e_empty;
				corrupt_q   <= e_bad;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Empty marker always closes the list with a zero value
	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_list |-> last && !corrupt && value == '0)
		else $error("empty marker malformed");

	// Corrupt result always closes the list with a zero value
	a_corrupt_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && corrupt |-> last && !empty_list && value == '0)
		else $error("corrupt result malformed");

	// Truncation point and divisor never reach zero
	a_trunc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		sq_q == SQ_BITS |-> trunc_q != '0 && m_q != '0)
		else $error("zero divisor or truncation point");

	// Divider always has steps left while running
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		sq_q == SQ_DIV |-> it_q != '0)
		else $error("divider step count exhausted");

	// No new result while the held one is refused
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !emit_fire)
		else $error("result overwritten");

endmodule

// ===== tb/sv/tb.sv =====
module tb;

	localparam int HDR_W        = 16;
	localparam int DRAIN_CYCLES = 300;
	localparam int STALL_LIMIT  = 4000;

	// Divisor rule: scale and offset terms, and the upper bound of t per small divisor
	localparam longint unsigned GOLOMB_A = 64'd5278688;
	localparam longint unsigned GOLOMB_B = 64'd7615537;
	localparam longint unsigned T_MAX    = 64'd167474174;
	localparam longint unsigned M_BOUND [10] = '{
		64'd29976418,  64'd45406673,  64'd60720539,  64'd75997183,  64'd91257138,
		64'd106508163, 64'd121753849, 64'd136996088, 64'd152235971, 64'd167474174
	};

	typedef enum logic [1:0] {LS_IDLE, LS_HEADER, LS_CODE, LS_DONE} list_state_t;
	typedef enum logic [1:0] {CW_UNARY, CW_REM, CW_EXTRA} cw_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} byte_req_t;

	typedef struct packed {
		logic [gsld_pkg::VALUE_W-1:0] value;
		logic                         last;
		logic                         empty_list;
		logic                         corrupt;
	} list_res_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_wr_en = 1'b0;
	logic [gsld_pkg::UNIV_W-1:0]  cfg_wr_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [7:0]                   data_byte = '0;
	logic                         start_list = 1'b0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [gsld_pkg::VALUE_W-1:0] value;
	logic                         last;
	logic                         empty_list;
	logic                         corrupt;

	golomb_sorted_list_decoder_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.start_list  (start_list),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value       (value),
		.last        (last),
		.empty_list  (empty_list),
		.corrupt     (corrupt)
	);

	always #10 clk = ~clk;

	// Decoder state mirrored for prediction
	logic [gsld_pkg::UNIV_W-1:0] universe_cfg = '0;
	list_state_t       ls = LS_IDLE;
	cw_state_t         cw = CW_UNARY;
	logic [15:0]       hdr_acc = '0;
	logic [4:0]        bits_left = '0;
	logic [15:0]       vals_left = '0;
	logic [25:0]       run_val = '0;
	logic [23:0]       div_m = 24'd1;
	logic [4:0]        rem_w = '0;
	logic [24:0]       trunc_p = 25'd1;
	logic [24:0]       rem_acc = '0;

	byte_req_t req_queue[$];
	list_res_t want_results[$];
	bit        list_bits[$];
	byte_req_t next_req;

	int err_count = 0;
	int stim_bytes = 0;
	int bytes_taken = 0;
	int values_checked = 0;
	int empties_seen = 0;
	int corrupt_seen = 0;
	int settings_used = 0;
	int send_idle_pct = 30;
	int recv_stall_pct = 30;
	int send_gap = 0;
	int recv_hold = 0;
	int idle_cycles = 0;

	function automatic int code_len(input longint unsigned m);
		int k;
		k = 0;
		while (k < 40 && (64'd1 << k) <= m)
			k++;
		return k;
	endfunction

	function automatic logic [23:0] golomb_m(input longint unsigned span,
			input longint unsigned cnt);
		longint unsigned t;
		if (cnt == 0)
			return 24'd1;
		t = (2 * GOLOMB_A * span) / cnt + (GOLOMB_B - GOLOMB_A);
		if (t <= T_MAX) begin
			for (int i = 0; i < 10; i++)
				if (t <= M_BOUND[i])
					return 24'(i + 1);
		end
		return 24'(t / (2 * GOLOMB_B));
	endfunction

	task automatic emit(input logic [gsld_pkg::VALUE_W-1:0] v, input logic lst,
			input logic emp, input logic bad);
		want_results.push_back('{value: v, last: lst, empty_list: emp, corrupt: bad});
	endtask

	// Header complete: emit the empty marker for a zero count, else derive the divisor and open the list
	task automatic open_list();
		int k;
		if (hdr_acc == 0) begin
			emit('0, 1'b1, 1'b1, 1'b0);
			ls = LS_DONE;
			return;
		end
		vals_left = hdr_acc;
		run_val = 26'(universe_cfg + hdr_acc + 1);
		div_m = golomb_m(longint'(universe_cfg) + hdr_acc, hdr_acc);
		k = code_len(div_m);
		rem_w = 5'(k);
		trunc_p = 25'((64'd1 << k) - div_m);
		rem_acc = '0;
		cw = CW_UNARY;
		ls = LS_CODE;
	endtask

	// Subtract the remainder and emit the new value
	task automatic close_codeword();
		logic [25:0] v;
		v = (run_val >= rem_acc) ? run_val - rem_acc : '0;
		run_val = v;
		cw = CW_UNARY;
		rem_acc = '0;
		if (vals_left > 0)
			vals_left--;
		if (v == 0) begin
			emit('0, 1'b1, 1'b0, 1'b1);
			ls = LS_DONE;
			return;
		end
		emit(v[gsld_pkg::VALUE_W-1:0], vals_left == 0, 1'b0, 1'b0);
		if (vals_left == 0)
			ls = LS_DONE;
	endtask

	task automatic remainder_end();
		if (rem_acc >= trunc_p)
			cw = CW_EXTRA;
		else
			close_codeword();
	endtask

	task automatic code_bit(input logic b);
		case (cw)
			CW_UNARY: begin
				if (b) begin
					run_val = (run_val >= div_m) ? run_val - div_m : '0;
				end else begin
					rem_acc = '0;
					bits_left = (rem_w > 0) ? rem_w - 5'd1 : '0;
					if (bits_left == 0)
						remainder_end();
					else
						cw = CW_REM;
				end
			end
			CW_REM: begin
				rem_acc = (rem_acc << 1) | 25'(b);
				if (bits_left > 0)
					bits_left--;
				if (bits_left == 0)
					remainder_end();
			end
			default: begin
				rem_acc = ((rem_acc << 1) | 25'(b)) - trunc_p;
				close_codeword();
			end
		endcase
	endtask

	// Run one accepted request through the bit-serial decode
	task automatic decode_byte(input logic [7:0] b8, input logic st);
		if (st) begin
			ls = LS_HEADER;
			hdr_acc = '0;
			bits_left = 5'(HDR_W);
			vals_left = '0;
			rem_acc = '0;
			cw = CW_UNARY;
		end
		for (int i = 7; i >= 0; i--) begin
			if (ls == LS_HEADER) begin
				hdr_acc = {hdr_acc[14:0], b8[i]};
				if (bits_left > 0)
					bits_left--;
				if (bits_left == 0)
					open_list();
			end else if (ls == LS_CODE) begin
				code_bit(b8[i]);
			end else begin
				break;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input longint unsigned want_v,
			input longint unsigned got_v);
		$display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h",
			$time, what, want_v, got_v);
		err_count++;
	endtask

	task automatic check_result();
		list_res_t want;
		if (want_results.size() == 0) begin
			report_mismatch("unexpected result value", 0, value);
			return;
		end
		want = want_results.pop_front();
		if (value !== want.value)
			report_mismatch("value", want.value, value);
		if (last !== want.last)
			report_mismatch("last", want.last, last);
		if (empty_list !== want.empty_list)
			report_mismatch("empty_list", want.empty_list, empty_list);
		if (corrupt !== want.corrupt)
			report_mismatch("corrupt", want.corrupt, corrupt);
		values_checked++;
		if (want.empty_list)
			empties_seen++;
		if (want.corrupt)
			corrupt_seen++;
	endtask

	function automatic int pick_idle();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offer requests from the queue, holding each until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				decode_byte(data_byte, start_list);
				bytes_taken++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (req_queue.size() > 0) begin
					next_req = req_queue.pop_front();
					data_byte <= next_req.data;
					start_list <= next_req.start;
					in_valid <= 1'b1;
					if ($urandom_range(0, 99) < send_idle_pct)
						send_gap = pick_idle();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Take results and stall the output at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_result();
			if (recv_hold > 0) begin
				recv_hold--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 99) < recv_stall_pct) begin
				recv_hold = pick_idle() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Count cycles with work outstanding but no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(req_queue.size() == 0 && !in_valid && want_results.size() == 0))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[%0t] no progress for %0d cycles, %0d results outstanding",
					$time, idle_cycles, want_results.size());
				$display("golomb_sorted_list_decoder_core verification failed");
				$finish;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic st);
		req_queue.push_back('{data: b, start: st});
		stim_bytes++;
	endtask

	task automatic add_bits(input longint unsigned v, input int w);
		for (int i = w - 1; i >= 0; i--)
			list_bits.push_back(v[i]);
	endtask

	// Encode a list for the current universe; optionally drive the last gap
	// past zero, or cut the stream short so that the next list restarts it
	task automatic queue_list(input int unsigned len, input bit sink, input int cut);
		longint unsigned run, gap, q, d, mm, p;
		int k, nbytes;
		logic [7:0] b;
		list_bits.delete();
		add_bits(len, HDR_W);
		if (len > 0) begin
			mm = golomb_m(longint'(universe_cfg) + len, len);
			k = code_len(mm);
			p = (64'd1 << k) - mm;
			run = longint'(universe_cfg) + len + 1;
			for (int j = 0; j < len; j++) begin
				if (cut > 0 && list_bits.size() > cut * 8)
					break;
				if (sink && j == len - 1 && run / mm <= 40) begin
					gap = run + $urandom_range(0, mm - 1);
				end else begin
					gap = $urandom_range(0, 3) * mm + $urandom_range(0, mm - 1);
					if (gap > run - 1)
						gap = run - 1;
				end
				q = gap / mm;
				d = gap % mm;
				repeat (q)
					add_bits(1, 1);
				add_bits(0, 1);
				if (d < p)
					add_bits(d, k - 1);
				else
					add_bits(d + p, k);
				run = (gap >= run) ? 0 : run - gap;
			end
		end
		// Fill the last byte with junk bits
		while (list_bits.size() % 8 != 0)
			list_bits.push_back($urandom_range(0, 1));
		nbytes = list_bits.size() / 8;
		if (cut > 0 && nbytes > cut)
			nbytes = cut;
		for (int i = 0; i < nbytes; i++) begin
			for (int j = 0; j < 8; j++)
				b = {b[6:0], list_bits[i * 8 + j]};
			push_byte(b, i == 0);
		end
	endtask

	task automatic queue_noise();
		push_byte(8'($urandom_range(0, 255)), 1'b1);
		repeat ($urandom_range(1, 5))
			push_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic queue_random_list();
		int unsigned pick, len;
		pick = $urandom_range(0, 99);
		if (universe_cfg < 4096 && $urandom_range(0, 3) == 0)
			len = $urandom_range(13, 64);
		else
			len = $urandom_range(1, 12);
		if (pick < 8)
			queue_list(0, 1'b0, 0);
		else if (pick < 16)
			queue_noise();
		else if (pick < 26)
			queue_list($urandom_range(1, 65535), 1'b0, $urandom_range(1, 4));
		else if (pick < 34)
			queue_list($urandom_range(1, 6), 1'b1, 0);
		else
			queue_list(len, 1'b0, 0);
		// Stray bytes after the list, dropped once it has ended
		if ($urandom_range(0, 99) < 12)
			push_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic set_universe(input logic [gsld_pkg::UNIV_W-1:0] n);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= n;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		universe_cfg = n;
		settings_used++;
	endtask

	// Hold off until every request is taken and every result is back
	task automatic drain_phase();
		do
			@(negedge clk);
		while (req_queue.size() > 0 || in_valid || want_results.size() > 0);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	function automatic int pick_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 45;
		endcase
	endfunction

	initial begin
		int base;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;

		// Smallest universe: stray byte while idle, empty list, one-value list,
		// restart in the middle of a header
		set_universe('0);
		push_byte(8'h5A, 1'b0);
		queue_list(0, 1'b0, 0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		queue_list(1, 1'b0, 0);
		drain_phase();

		// Largest universe: widest remainder, underflow, maximal count cut short
		set_universe('1);
		queue_list(1, 1'b0, 0);
		queue_list(2, 1'b1, 0);
		queue_list(16'hFFFF, 1'b0, 3);
		queue_list(3, 1'b0, 0);
		drain_phase();

		// Divisor of one: a full byte of codewords
		set_universe(24'd9);
		push_byte(8'h00, 1'b1);
		push_byte(8'h18, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		drain_phase();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_universe('1);
				1: set_universe('0);
				2: set_universe(24'($urandom_range(1, 255)));
				3: set_universe(24'($urandom_range(256, 65535)));
				default: set_universe(24'($urandom_range(0, 24'hFFFFFF)));
			endcase
			send_idle_pct = pick_pct();
			recv_stall_pct = pick_pct();
			base = stim_bytes;
			while (stim_bytes - base < 35)
				queue_random_list();
			drain_phase();
		end

		$display("Sent %0d bytes under %0d universe sizes; checked %0d results",
			bytes_taken, settings_used, values_checked);
		$display("including %0d empty lists and %0d corrupt list ends",
			empties_seen, corrupt_seen);
		if (err_count == 0)
			$display("golomb_sorted_list_decoder_core verification clean");
		else
			$display("golomb_sorted_list_decoder_core verification failed");
		$finish;
	end

endmodule
